// File: sv/tlb_lru_fully_associative_defines.svh
// ----------------------------------------------------------------------------
// TLB assertion macros
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TLB_LRU_FULLY_ASSOCIATIVE_DEFINES_SVH
`define TLB_LRU_FULLY_ASSOCIATIVE_DEFINES_SVH

// same-cycle implication
`define TLB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tlb_lru_pkg.sv
// ----------------------------------------------------------------------------
// TLB package
// Action codes, default geometry and fixed widths of the translation buffer.
// ----------------------------------------------------------------------------
package tlb_lru_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int PROCESS_BITS_DEF = 7;
  localparam int PAGE_BITS_DEF    = 10;
  localparam int FRAME_BITS_DEF   = 10;

  localparam int ACTION_BITS = 3;
  localparam int CFG_BITS    = 5;
  localparam int STAMP_BITS  = 32;

  localparam logic [CFG_BITS-1:0] COUNT_RESET = CFG_BITS'(16);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LOOKUP     = 3'd0,
    ACT_FILL       = 3'd1,
    ACT_FLUSH_PROC = 3'd2,
    ACT_INVAL_PAGE = 3'd3,
    ACT_FLUSH_ALL  = 3'd4
  } action_t;

endpackage

// File: sv/tlb_lru_fully_associative.sv
// ----------------------------------------------------------------------------
// Fully associative TLB with LRU replacement
// Lookup, fill and invalidation keyed by process id and page number.
// ----------------------------------------------------------------------------
// Usage:
//   Input: raise start with in_action and tag fields; the transaction is taken
//   at the clock edge where start is high and busy is low. busy stays low, so
//   a transaction may be issued every cycle.
//   Output: each transaction yields one result, shown for exactly one cycle
//   with out_valid high, after the input register and then the result
//   register. The receiver cannot stall; results must be taken as shown.
//   Throughput: one transaction per cycle. The path that sets it is the
//   parallel tag compare plus the log2(ENTRIES)-level stamp minimum tree that
//   picks the replacement victim, between the input and result registers.
//   Config: cfg_write_en with cfg_entries_in_use sets the slot count and
//   clears every valid bit; write only while no transaction is in flight.
//   A count of zero disables the buffer.
//   Reset: synchronous, active low; clears valid bits and the use counter,
//   sets the slot count to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "tlb_lru_fully_associative_defines.svh"

module tlb_lru_fully_associative
  import tlb_lru_pkg::*;
#(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int PROCESS_BITS = PROCESS_BITS_DEF,
  parameter int PAGE_BITS    = PAGE_BITS_DEF,
  parameter int FRAME_BITS   = FRAME_BITS_DEF,
  localparam int SLOT_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACTION_BITS-1:0]  in_action,
  input  logic [PROCESS_BITS-1:0] in_process_id,
  input  logic [PAGE_BITS-1:0]    in_page_number,
  input  logic [FRAME_BITS-1:0]   in_frame_number,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic [FRAME_BITS-1:0]   out_frame,
  output logic [SLOT_BITS-1:0]    out_slot,
  output logic                    out_evicted,
  input  logic                    cfg_write_en,
  input  logic [CFG_BITS-1:0]     cfg_entries_in_use
);

  localparam int LEAVES = 1 << $clog2(ENTRIES);

  logic                    req_valid_r;
  action_t                 req_action_r;
  logic [PROCESS_BITS-1:0] req_process_r;
  logic [PAGE_BITS-1:0]    req_page_r;
  logic [FRAME_BITS-1:0]   req_frame_r;

  logic [ENTRIES-1:0]      valid_r;
  logic [ENTRIES-1:0]      valid_nxt;
  logic [PROCESS_BITS-1:0] proc_r  [ENTRIES];
  logic [PAGE_BITS-1:0]    page_r  [ENTRIES];
  logic [FRAME_BITS-1:0]   frame_r [ENTRIES];
  logic [STAMP_BITS-1:0]   stamp_r [ENTRIES];
  logic [STAMP_BITS-1:0]   counter_r;
  logic [CFG_BITS-1:0]     count_r;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [FRAME_BITS-1:0]   out_frame_r;
  logic [SLOT_BITS-1:0]    out_slot_r;
  logic                    out_evicted_r;

  logic [ENTRIES-1:0]      in_use;
  logic [ENTRIES-1:0]      tag_hit;
  logic [ENTRIES-1:0]      proc_hit;
  logic [ENTRIES-1:0]      free_vec;
  logic [SLOT_BITS-1:0]    match_idx;
  logic [SLOT_BITS-1:0]    free_idx;

  logic                    node_en    [1:2*LEAVES-1];
  logic [STAMP_BITS-1:0]   node_stamp [1:2*LEAVES-1];
  logic [SLOT_BITS-1:0]    node_idx   [1:2*LEAVES-1];
  logic                    take_right [1:2*LEAVES-1];

  logic                    enabled;
  logic                    any_match;
  logic                    any_free;
  logic                    lookup_hit;
  logic                    fill_do;
  logic [SLOT_BITS-1:0]    fill_idx;

  assign busy = 1'b0;

  // tag compare and slot selection
  always_comb begin
    in_use    = '0;
    tag_hit   = '0;
    proc_hit  = '0;
    free_vec  = '0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      in_use[i]   = int'(count_r) > i;
      proc_hit[i] = valid_r[i] && in_use[i] && (proc_r[i] == req_process_r);
      tag_hit[i]  = proc_hit[i] && (page_r[i] == req_page_r);
      free_vec[i] = !valid_r[i] && in_use[i];
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tag_hit[i]) begin
        match_idx = SLOT_BITS'(i);
      end
      if (free_vec[i]) begin
        free_idx = SLOT_BITS'(i);
      end
    end
  end

  // LRU victim: smallest stamp, highest index on ties
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_en[LEAVES+i]    = 1'b0;
      node_stamp[LEAVES+i] = '0;
      node_idx[LEAVES+i]   = SLOT_BITS'(i);
      take_right[LEAVES+i] = 1'b0;
      if (i < ENTRIES) begin
        node_en[LEAVES+i]    = in_use[i];
        node_stamp[LEAVES+i] = stamp_r[i];
      end
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      take_right[k] = node_en[2*k+1] &&
                      (!node_en[2*k] || (node_stamp[2*k+1] <= node_stamp[2*k]));
      node_en[k]    = node_en[2*k] || node_en[2*k+1];
      node_stamp[k] = take_right[k] ? node_stamp[2*k+1] : node_stamp[2*k];
      node_idx[k]   = take_right[k] ? node_idx[2*k+1] : node_idx[2*k];
    end
  end

  assign enabled    = (count_r != '0);
  assign any_match  = |tag_hit;
  assign any_free   = |free_vec;
  assign lookup_hit = req_valid_r && (req_action_r == ACT_LOOKUP) && any_match;
  assign fill_do    = req_valid_r && (req_action_r == ACT_FILL) && enabled;
  assign fill_idx   = any_free ? free_idx : node_idx[1];

  always_comb begin
    valid_nxt = valid_r;
    if (req_valid_r) begin
      case (req_action_r)
        ACT_LOOKUP: begin
          valid_nxt = valid_r;
        end
        ACT_FILL: begin
          if (enabled) begin
            valid_nxt[fill_idx] = 1'b1;
          end
        end
        ACT_FLUSH_PROC: begin
          valid_nxt = valid_r & ~proc_hit;
        end
        ACT_INVAL_PAGE: begin
          valid_nxt = valid_r & ~tag_hit;
        end
        ACT_FLUSH_ALL: begin
          if (enabled) begin
            valid_nxt = '0;
          end
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      counter_r   <= '0;
      count_r     <= COUNT_RESET;
    end else begin
      req_valid_r <= start && !busy;
      out_valid_r <= req_valid_r;
      if (cfg_write_en) begin
        count_r <= cfg_entries_in_use;
        valid_r <= '0;
      end else begin
        valid_r <= valid_nxt;
      end
      if (lookup_hit || fill_do) begin
        counter_r <= counter_r + STAMP_BITS'(1);
      end
    end
  end

  // transaction payload and results
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_action_r  <= action_t'(in_action);
      req_process_r <= in_process_id;
      req_page_r    <= in_page_number;
      req_frame_r   <= in_frame_number;
    end
    out_hit_r     <= lookup_hit;
    out_frame_r   <= lookup_hit ? frame_r[match_idx] : '0;
    out_slot_r    <= lookup_hit ? match_idx : (fill_do ? fill_idx : '0);
    out_evicted_r <= fill_do && !any_free;
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (fill_do) begin
      proc_r[fill_idx]  <= req_process_r;
      page_r[fill_idx]  <= req_page_r;
      frame_r[fill_idx] <= req_frame_r;
      stamp_r[fill_idx] <= counter_r;
    end else if (lookup_hit) begin
      stamp_r[match_idx] <= counter_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_frame   = out_frame_r;
  assign out_slot    = out_slot_r;
  assign out_evicted = out_evicted_r;

  `TLB_ASSERT_NEXT(a_result_follows, req_valid_r, out_valid, "accepted transaction gave no result")
  `TLB_ASSERT_IMPLY(a_result_has_cause, out_valid, $past(req_valid_r), "result without transaction")
  `TLB_ASSERT_IMPLY(a_hit_no_evict, out_valid && out_hit, !out_evicted, "hit reported eviction")
  `TLB_ASSERT_IMPLY(a_counter_moves, counter_r != $past(counter_r), out_valid, "counter moved while idle")

endmodule
